/* src/pfl_pkg.sv */
// ----------------------------------------------------------------------------
// pfl_pkg
// Shared types and constants of the page free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfl_pkg;

	localparam int MAX_PAGES  = 4096;
	localparam int GROW_PAGES = 100;
	localparam int PAGE_SPACE = 4096;
	localparam int PAGE_LIMIT = (MAX_PAGES < PAGE_SPACE) ? MAX_PAGES : PAGE_SPACE;

	localparam int PAGE_W  = 12;
	localparam int COUNT_W = 13;
	localparam int SUM_W   = 14;
	localparam int GIDX_W  = (GROW_PAGES > 1) ? $clog2(GROW_PAGES) : 1;

	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_FREE    = 1'b1;
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic              command;
		logic [PAGE_W-1:0] page_to_free;
	} cmd_word_t;

	typedef struct packed {
		logic [PAGE_W-1:0] page_number;
		logic              status;
		logic              grew;
	} res_word_t;

	typedef struct packed {
		logic              en;
		logic [PAGE_W-1:0] addr;
		logic [PAGE_W-1:0] data;
	} link_wr_t;

	typedef struct packed {
		logic              en;
		logic [PAGE_W-1:0] addr;
	} link_rd_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_POP  = 4'b0010,
		ST_GROW = 4'b0100,
		ST_HOLD = 4'b1000
	} eng_state_t;

endpackage

`default_nettype wire

/* src/page_free_list_allocator_top.sv */
// ----------------------------------------------------------------------------
// page_free_list_allocator_top
// Page allocator over a linked free list kept in an on-chip link memory.
// ----------------------------------------------------------------------------
//
//   channel | ports                        | word        | direction
//   --------+------------------------------+-------------+----------
//   command | in_valid, in_stall, in_data  | cmd_word_t  | into block
//   result  | out_valid, out_stall, out_data | res_word_t | out of block
//
// Steps: a free or a refused allocate is answered from ST_IDLE; an allocate
// from a non-empty list reads the head's link in ST_IDLE (one link memory
// read, registered data) and answers from ST_POP; an allocate that grows the
// store walks ST_GROW, one link write per page of the new block.
// Reset clears the head (list empty) and sets the page count to 1; the link
// memory is not cleared, since only written entries are ever read.
// in_stall rises while a command is in work, and while a result waits behind
// a stalled output register; the output register holds one more word.
// ----------------------------------------------------------------------------
`default_nettype none

module page_free_list_allocator_top
	import pfl_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire cmd_word_t in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output res_word_t      out_data
);

	link_wr_t          link_wr;
	link_rd_t          link_rd;
	logic [PAGE_W-1:0] link_data;

	logic      out_ready;
	logic      res_valid;
	res_word_t res;

	logic      out_valid_q;
	res_word_t out_data_q;

	// Link store: next-page pointer of every free page.
	pfl_link_ram u_link_ram (
		.clk     (clk),
		.wr      (link_wr),
		.rd      (link_rd),
		.rd_data (link_data)
	);

	// Sequencer: head, page count, growth walk.
	pfl_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.in_stall  (in_stall),
		.out_ready (out_ready),
		.res_valid (res_valid),
		.res       (res),
		.link_wr   (link_wr),
		.link_rd   (link_rd),
		.link_data (link_data)
	);

	// Output register: take a new word when empty or when the current one leaves.
	assign out_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the payload; load only with a fresh result.
	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// A grown allocate always hands out a real page.
	a_grow_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.grew |-> (res.status == STATUS_OK) && (res.page_number != '0))
		else $error("growth result without a page");

	// A refusal carries no page and no growth.
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == STATUS_FULL) |-> (res.page_number == '0) && !res.grew)
		else $error("refused allocate carries data");

	// The sequencer never overwrites a word that is still waiting.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !res_valid)
		else $error("result pushed into a stalled output register");

	// An accepted command blocks the next one until its result is handed over.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !res_valid |=> in_stall)
		else $error("second command accepted while one is in work");

endmodule

`default_nettype wire

/* src/pfl_link_ram.sv */
// ----------------------------------------------------------------------------
// pfl_link_ram
// Next-page link store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfl_link_ram
	import pfl_pkg::*;
(
	input  wire logic              clk,
	input  wire link_wr_t          wr,
	input  wire link_rd_t          rd,
	output logic      [PAGE_W-1:0] rd_data
);

	logic [PAGE_W-1:0] mem [PAGE_SPACE];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

`default_nettype wire

/* src/pfl_engine.sv */
// ----------------------------------------------------------------------------
// pfl_engine
// Command sequencer: pops, pushes and grows the free list in the link store.
// ----------------------------------------------------------------------------
`default_nettype none

module pfl_engine
	import pfl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire cmd_word_t         in_data,
	output logic                   in_stall,
	input  wire logic              out_ready,
	output logic                   res_valid,
	output res_word_t              res,
	output link_wr_t               link_wr,
	output link_rd_t               link_rd,
	input  wire logic [PAGE_W-1:0] link_data
);

	eng_state_t         state_q, state_d;
	logic  [PAGE_W-1:0] head_q;
	logic [COUNT_W-1:0] count_q;
	logic  [GIDX_W-1:0] gidx_q;
	res_word_t          hold_q;

	res_word_t          res_now;
	logic               done;
	logic               free_ok;
	logic               store_full;
	logic               grow_last;
	logic  [PAGE_W-1:0] grow_page;

	assign free_ok    = (in_data.page_to_free != '0)
		&& (COUNT_W'(in_data.page_to_free) < count_q);
	assign store_full = (SUM_W'(count_q) + SUM_W'(GROW_PAGES)) > SUM_W'(PAGE_LIMIT);
	assign grow_last  = (gidx_q == GIDX_W'(GROW_PAGES - 1));
	assign grow_page  = count_q[PAGE_W-1:0] + PAGE_W'(gidx_q);

	always_comb begin
		link_wr = '0;
		link_rd = '0;
		done    = 1'b0;
		res_now = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_data.command == CMD_FREE) begin
						done = 1'b1;
						if (free_ok) begin
							link_wr = '{en: 1'b1, addr: in_data.page_to_free, data: head_q};
						end
					end else if (head_q != '0) begin
						link_rd = '{en: 1'b1, addr: head_q};
						state_d = ST_POP;
					end else if (store_full) begin
						done           = 1'b1;
						res_now.status = STATUS_FULL;
					end else begin
						state_d = ST_GROW;
					end
				end
			end
			ST_POP: begin
				done                = 1'b1;
				res_now.page_number = head_q;
			end
			ST_GROW: begin
				link_wr.en   = 1'b1;
				link_wr.addr = grow_page;
				link_wr.data = grow_last ? '0 : grow_page + PAGE_W'(1);
				if (grow_last) begin
					done                = 1'b1;
					res_now.page_number = count_q[PAGE_W-1:0];
					res_now.grew        = 1'b1;
				end
			end
			ST_HOLD: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (done) begin
			state_d = out_ready ? ST_IDLE : ST_HOLD;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_HOLD) ? out_ready : (done && out_ready);
	assign res       = (state_q == ST_HOLD) ? hold_q : res_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			count_q <= COUNT_W'(1);
			gidx_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					gidx_q <= '0;
					if (in_valid && (in_data.command == CMD_FREE) && free_ok) begin
						head_q <= in_data.page_to_free;
					end
				end
				ST_POP: begin
					head_q <= link_data;
				end
				ST_GROW: begin
					gidx_q <= gidx_q + GIDX_W'(1);
					if (grow_last) begin
						count_q <= count_q + COUNT_W'(GROW_PAGES);
						head_q  <= (GROW_PAGES > 1) ? count_q[PAGE_W-1:0] + PAGE_W'(1) : '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Park a finished result while the output register is occupied.
	always_ff @(posedge clk) begin
		if (done && !out_ready) begin
			hold_q <= res_now;
		end
	end

endmodule

`default_nettype wire

/* dv/tb_page_free_list_allocator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_free_list_allocator_top
// Self-checking bench for the free-list page allocator: a negedge driver feeds
// command words from a queue, a posedge monitor checks every result word
// against an in-bench model of the head pointer, page count and link store.
// ----------------------------------------------------------------------------

module tb_page_free_list_allocator_top;
	import pfl_pkg::*;

	// Cycles without any handshake before the run is called hung; a grow plus
	// the longest gaps on both sides, and the long receiver hold-off, are well
	// under this.
	localparam int WATCH_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 2 * GROW_PAGES + 20;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_WORDS = 1333;
	// Keep noise frees this far above the page count, so that a grow landing
	// between generation and acceptance cannot turn them into real frees.
	localparam int NOISE_MARGIN = 4 * GROW_PAGES;

	logic      clk;
	logic      arst_n;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	cmd_word_t in_data   = '0;
	logic      out_valid;
	logic      out_stall = 1'b1;
	res_word_t out_data;

	page_free_list_allocator_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	// Command words waiting for the driver, and result words still owed.
	cmd_word_t cmd_pending[$];
	res_word_t grant_expect[$];
	// Pages handed out and not yet returned; frees are drawn from here so that
	// random traffic never pushes a page that is already on the list.
	int        held_pages[$];

	// Model state of the allocator.
	logic [PAGE_W-1:0] link_mem[PAGE_SPACE];
	logic [PAGE_W-1:0] head_page  = '0;
	int                pages_made = 1;

	int   words_sent  = 0;
	int   words_taken = 0;
	bit   word_taken  = 1'b0;
	bit   failed      = 1'b0;
	int   send_wait   = 0;
	int   recv_wait   = 0;
	int   long_hold   = 0;
	bit   send_calm   = 1'b0;
	bit   recv_calm   = 1'b0;
	int   idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	// Apply one accepted command to the model and queue the result it owes.
	task automatic apply_command(input cmd_word_t w);
		res_word_t r;
		int        idx[$];
		r.page_number = '0;
		r.status      = STATUS_OK;
		r.grew        = 1'b0;
		if (w.command == CMD_ALLOC) begin
			if (head_page == '0) begin
				// Empty list: grow by one block chained in ascending order,
				// or refuse without touching anything when over the limit.
				if (pages_made + GROW_PAGES > PAGE_LIMIT) begin
					r.status = STATUS_FULL;
				end else begin
					for (int i = 0; i < GROW_PAGES; i++)
						link_mem[pages_made + i] = (i + 1 < GROW_PAGES) ?
							PAGE_W'(pages_made + i + 1) : '0;
					head_page  = PAGE_W'(pages_made);
					pages_made += GROW_PAGES;
					r.grew     = 1'b1;
				end
			end
			if (r.status == STATUS_OK) begin
				r.page_number = head_page;
				head_page     = link_mem[head_page];
				held_pages.push_back(int'(r.page_number));
			end
		end else if (w.page_to_free != '0 && int'(w.page_to_free) < pages_made) begin
			// Push onto the head; the header page and uncreated pages drop out.
			link_mem[w.page_to_free] = head_page;
			head_page                = w.page_to_free;
			idx = held_pages.find_first_index(p) with (p == int'(w.page_to_free));
			if (idx.size() > 0)
				held_pages.delete(idx[0]);
		end
		grant_expect.push_back(r);
	endtask

	// Queue one command word; hold while the driver is two words ahead.
	task automatic send(input logic cmd, input int page);
		cmd_word_t w;
		while (cmd_pending.size() >= 2)
			@(posedge clk);
		w.command      = cmd;
		w.page_to_free = PAGE_W'(page);
		cmd_pending.push_back(w);
		words_sent++;
	endtask

	// One random command: allocate, return a held page, or a free that the
	// block must drop (header page, last page, or far above the page count).
	task automatic random_command(input int alloc_pct);
		int roll;
		int idx;
		int pg;
		roll = $urandom_range(0, 99);
		if (roll < alloc_pct || (roll < 92 && held_pages.size() == 0)) begin
			send(CMD_ALLOC, $urandom_range(0, PAGE_SPACE - 1));
		end else if (roll < 92) begin
			idx = $urandom_range(0, held_pages.size() - 1);
			pg  = held_pages[idx];
			held_pages.delete(idx);
			send(CMD_FREE, pg);
		end else begin
			case ($urandom_range(0, 2))
				0: pg = 0;
				1: pg = PAGE_SPACE - 1;
				default: begin
					if (pages_made + NOISE_MARGIN < PAGE_SPACE)
						pg = $urandom_range(pages_made + NOISE_MARGIN, PAGE_SPACE - 1);
					else
						pg = 0;
				end
			endcase
			send(CMD_FREE, pg);
		end
	endtask

	// Stimulus: directed corners, random traffic, then a double free.
	initial begin
		int pg;
		@(posedge arst_n);
		@(posedge clk);

		// Free the header page and a page never created, then grow on the
		// first allocate and recycle the first two pages.
		send(CMD_FREE, 0);
		send(CMD_FREE, 1);
		send(CMD_ALLOC, PAGE_SPACE - 1);
		send(CMD_ALLOC, 0);
		send(CMD_FREE, 2);
		send(CMD_FREE, 1);
		send(CMD_ALLOC, 0);
		send(CMD_ALLOC, 0);
		send(CMD_FREE, PAGE_SPACE - 1);
		// Exactly the page count: one past the last created page, dropped.
		send(CMD_FREE, 1 + GROW_PAGES);
		send(CMD_FREE, 2);
		send(CMD_ALLOC, 0);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			// Hold the receiver off for a long stretch once, with the sender
			// still offering, so the block backs up and stalls its input.
			if (n == RANDOM_WORDS / 2)
				long_hold = HOLD_CYCLES;
			random_command(55);
		end

		// Double free last: it leaves a loop on the list that never empties.
		pg = held_pages.pop_front();
		send(CMD_FREE, pg);
		send(CMD_FREE, pg);
		send(CMD_ALLOC, 0);
		send(CMD_ALLOC, 0);
		send(CMD_ALLOC, 0);

		while (words_taken < words_sent)
			@(posedge clk);
		while (grant_expect.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed && grant_expect.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Driver: change inputs on the falling edge; hold the word while stalled.
	always @(negedge clk) begin
		bit busy;
		busy       = in_valid && !word_taken;
		word_taken = 1'b0;
		if (arst_n && !busy) begin
			if (send_wait > 0) begin
				send_wait--;
				in_valid <= 1'b0;
			end else if (cmd_pending.size() > 0) begin
				in_data  <= cmd_pending.pop_front();
				in_valid <= 1'b1;
				// Draw the gap before the next word; flip to bursts now and then.
				if ($urandom_range(0, 39) == 0)
					send_calm = !send_calm;
				send_wait = send_calm ? 0 : $urandom_range(0, 16);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall through the long hold-off, then per-word waits.
	always @(negedge clk) begin
		if (long_hold > 0) begin
			long_hold--;
			out_stall <= 1'b1;
		end else if (recv_wait > 0) begin
			recv_wait--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: sample both handshakes on the rising edge; model each accepted
	// command and check each accepted result against the oldest one owed.
	always @(posedge clk) begin
		res_word_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				apply_command(in_data);
				word_taken = 1'b1;
				words_taken++;
			end
			if (out_valid && !out_stall) begin
				if ($urandom_range(0, 39) == 0)
					recv_calm = !recv_calm;
				recv_wait = recv_calm ? 0 : $urandom_range(0, 16);
				if (grant_expect.size() == 0) begin
					$error("result word with none owed: page_number %0d status %0d grew %0d",
						out_data.page_number, out_data.status, out_data.grew);
					failed = 1'b1;
				end else begin
					want = grant_expect.pop_front();
					if (out_data.page_number !== want.page_number) begin
						$error("page_number expected %0d got %0d",
							want.page_number, out_data.page_number);
						failed = 1'b1;
					end
					if (out_data.status !== want.status) begin
						$error("status expected %0d got %0d", want.status, out_data.status);
						failed = 1'b1;
					end
					if (out_data.grew !== want.grew) begin
						$error("grew expected %0d got %0d", want.grew, out_data.grew);
						failed = 1'b1;
					end
				end
			end
		end
	end

	// Watchdog: count cycles with no handshake on either channel.
	always @(posedge clk) begin
		if (arst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)))
			idle_cycles++;
		else
			idle_cycles = 0;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule
